@@ src/cled_pkg.sv @@
`default_nettype none

package cled_pkg;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_COLOR_ID = 1'b0;
  localparam logic REG_MODE_ID  = 1'b1;

  // Configuration reset values.
  localparam logic [10:0] COLOR_ID_RESET = 11'h102;
  localparam logic [10:0] MODE_ID_RESET  = 11'h200;

  // Action codes carried in payload byte 0.
  localparam logic [7:0] ACT_OFF    = 8'd0;
  localparam logic [7:0] ACT_ON     = 8'd1;
  localparam logic [7:0] ACT_BRIGHT = 8'd2;
  localparam logic [7:0] ACT_COLOR  = 8'd3;

  // Brightness limits and display reset state.
  localparam logic [6:0]  FULL_PCT           = 7'd100;
  localparam logic [7:0]  STORED_RED_RESET   = 8'd255;
  localparam logic [7:0]  STORED_GREEN_RESET = 8'd0;
  localparam logic [7:0]  STORED_BLUE_RESET  = 8'd0;
  localparam logic [23:0] SHOWN_RESET        = 24'h00FF00;

  // Division by 100 as a multiply by 5243 and shift right by 19,
  // exact for all products up to 255 * 100.
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // Command queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Decoded command kinds.
  typedef enum logic [2:0] {
    CMD_OFF,
    CMD_ON,
    CMD_BRIGHT,
    CMD_COLOR,
    CMD_NOP,
    CMD_AUTO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  level;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

@@ src/cled_front.sv @@
`default_nettype none

module cled_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [10:0]          color_frame_id,
  input  wire logic [10:0]          mode_frame_id,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [10:0]          frame_id,
  input  wire logic [7:0]           action,
  input  wire logic [7:0]           red_in,
  input  wire logic [7:0]           green_in,
  input  wire logic [7:0]           blue_in,
  input  wire logic [7:0]           level_in,
  output logic                      push,
  input  wire logic                 push_ready,
  output cled_pkg::cmd_t            push_cmd
);

  logic           cmd_valid;
  cled_pkg::cmd_t cmd;
  cled_pkg::cmd_t cls_cmd;
  logic           cls_keep;
  logic           accept;

  // Classify the frame by identifier and action.
  always_comb begin
    cls_cmd.red   = red_in;
    cls_cmd.green = green_in;
    cls_cmd.blue  = blue_in;
    cls_cmd.level = (level_in > {1'b0, cled_pkg::FULL_PCT}) ? cled_pkg::FULL_PCT
                                                            : level_in[6:0];
    cls_cmd.kind  = cled_pkg::CMD_NOP;
    cls_keep      = 1'b0;
    if (frame_id == color_frame_id) begin
      cls_keep = 1'b1;
      case (action)
        cled_pkg::ACT_OFF:    cls_cmd.kind = cled_pkg::CMD_OFF;
        cled_pkg::ACT_ON:     cls_cmd.kind = cled_pkg::CMD_ON;
        cled_pkg::ACT_BRIGHT: cls_cmd.kind = cled_pkg::CMD_BRIGHT;
        cled_pkg::ACT_COLOR:  cls_cmd.kind = cled_pkg::CMD_COLOR;
        default:              cls_cmd.kind = cled_pkg::CMD_NOP;
      endcase
    end else if (frame_id == mode_frame_id) begin
      case (action)
        cled_pkg::ACT_OFF: begin
          cls_keep     = 1'b1;
          cls_cmd.kind = cled_pkg::CMD_OFF;
        end
        cled_pkg::ACT_ON: begin
          cls_keep     = 1'b1;
          cls_cmd.kind = cled_pkg::CMD_AUTO;
        end
        default: cls_keep = 1'b0;
      endcase
    end
  end

  // One register stage in front of the queue.
  assign in_ready = !cmd_valid || push_ready;
  assign accept   = in_valid && in_ready;
  assign push     = cmd_valid;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= cls_keep;
    end else if (push_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

@@ src/cled_fifo.sv @@
`default_nettype none

module cled_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 push_ready,
  input  wire cled_pkg::cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop,
  output cled_pkg::cmd_t       pop_cmd
);

  cled_pkg::cmd_t                    entries [cled_pkg::FIFO_DEPTH];
  logic [cled_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [cled_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [cled_pkg::FIFO_CNT_W-1:0]   count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count != cled_pkg::FIFO_CNT_W'(cled_pkg::FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ src/cled_back.sv @@
`default_nettype none

module cled_back #(
  parameter int LED_COUNT = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_pop,
  input  wire cled_pkg::cmd_t  cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [5:0]           out_idx,
  output logic [23:0]          out_word,
  output logic                 out_last
);

  localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

  cled_pkg::back_state_t state;
  cled_pkg::back_state_t state_next;

  logic [7:0]  stored_red;
  logic [7:0]  stored_green;
  logic [7:0]  stored_blue;
  logic [6:0]  brightness_pct;
  logic        auto_mode;
  logic [23:0] shown_color;

  logic [7:0]  src_red;
  logic [7:0]  src_green;
  logic [7:0]  src_blue;
  logic [6:0]  src_pct;
  logic [14:0] prod_red;
  logic [14:0] prod_green;
  logic [14:0] prod_blue;
  logic [27:0] quo_red;
  logic [27:0] quo_green;
  logic [27:0] quo_blue;
  logic [5:0]  idx;
  logic        load;

  // Sequencer: next state, queue pop and output load.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    load       = 1'b0;
    case (state)
      cled_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            cled_pkg::CMD_AUTO: state_next = cled_pkg::ST_IDLE;
            cled_pkg::CMD_OFF,
            cled_pkg::CMD_NOP:  state_next = cled_pkg::ST_EMIT;
            default:            state_next = cled_pkg::ST_MUL;
          endcase
        end
      end
      cled_pkg::ST_MUL: state_next = cled_pkg::ST_DIV;
      cled_pkg::ST_DIV: state_next = cled_pkg::ST_EMIT;
      cled_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          load = 1'b1;
          if (idx == LAST_IDX) begin
            state_next = cled_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = cled_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cled_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Display state, updated when a command leaves the queue; the scaled color is stored in the divide state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_red     <= cled_pkg::STORED_RED_RESET;
      stored_green   <= cled_pkg::STORED_GREEN_RESET;
      stored_blue    <= cled_pkg::STORED_BLUE_RESET;
      brightness_pct <= cled_pkg::FULL_PCT;
      auto_mode      <= 1'b0;
      shown_color    <= cled_pkg::SHOWN_RESET;
    end else begin
      if (cmd_pop) begin
        case (cmd.kind)
          cled_pkg::CMD_AUTO: auto_mode <= 1'b1;
          cled_pkg::CMD_OFF: begin
            shown_color <= '0;
            auto_mode   <= 1'b0;
          end
          cled_pkg::CMD_BRIGHT: begin
            brightness_pct <= cmd.level;
            auto_mode      <= 1'b0;
          end
          cled_pkg::CMD_COLOR: begin
            if (!auto_mode) begin
              stored_red   <= cmd.red;
              stored_green <= cmd.green;
              stored_blue  <= cmd.blue;
            end
            auto_mode <= 1'b0;
          end
          default: auto_mode <= 1'b0;
        endcase
      end
      if (state == cled_pkg::ST_DIV) begin
        shown_color <= {quo_green[26:19], quo_red[26:19], quo_blue[26:19]};
      end
    end
  end

  // Operand capture for the scaling path.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.kind == cled_pkg::CMD_COLOR) begin
        src_red   <= cmd.red;
        src_green <= cmd.green;
        src_blue  <= cmd.blue;
      end else begin
        src_red   <= stored_red;
        src_green <= stored_green;
        src_blue  <= stored_blue;
      end
      case (cmd.kind)
        cled_pkg::CMD_BRIGHT: src_pct <= cmd.level;
        default:              src_pct <= auto_mode ? cled_pkg::FULL_PCT : brightness_pct;
      endcase
    end
  end

  // Scale each component by the percentage, then divide by 100.
  assign quo_red   = 28'(prod_red) * 28'(cled_pkg::DIV100_MUL);
  assign quo_green = 28'(prod_green) * 28'(cled_pkg::DIV100_MUL);
  assign quo_blue  = 28'(prod_blue) * 28'(cled_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    if (state == cled_pkg::ST_MUL) begin
      prod_red   <= 15'(src_red) * 15'(src_pct);
      prod_green <= 15'(src_green) * 15'(src_pct);
      prod_blue  <= 15'(src_blue) * 15'(src_pct);
    end
  end

  // LED counter for the refresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= (idx == LAST_IDX) ? 6'd0 : idx + 6'd1;
    end
  end

  // Output register: one transfer per LED word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx  <= idx;
      out_word <= shown_color;
      out_last <= (idx == LAST_IDX);
    end
  end

  // An auto-on command sets the flag and produces no refresh.
  a_auto_set: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == cled_pkg::CMD_AUTO) |=> (auto_mode && state == cled_pkg::ST_IDLE))
    else $error("auto command did not set auto mode");

  // The scaled color is ready when emission starts.
  a_div_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == cled_pkg::ST_DIV) |=> (state == cled_pkg::ST_EMIT && idx == 6'd0))
    else $error("refresh did not start at the first LED");

  // The last flag marks exactly the final LED of the chain.
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_idx == LAST_IDX)))
    else $error("last flag does not match LED index");

  // The counter never runs past the chain.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("LED counter out of range");

endmodule

`default_nettype wire

@@ src/can_commanded_led_color_controller.sv @@
// Frame-commanded LED color controller.
// The slave stream takes one received bus frame per transfer; color frames
// and mode frames with an on or off action become commands, other frames are dropped.
// The master stream sends one transfer per LED of the chain for every frame
// that changes the display: LED index and GRB word, tlast on the final LED.
// An auto-on mode frame updates the state and sends nothing.
// A frame passes the front register and the command queue; off and
// no-change commands then go straight to emission, and commands that
// scale the color first pass one multiply and one divide-by-100 step.
// Words then leave at one per cycle while the receiver is ready.
// A four-entry command queue lets new frames be taken while a refresh is
// still running; s_tready drops only when that queue and the front register
// are full. When the receiver stalls, the current word holds in the output
// register and the refresh pauses.
// Reset restores the frame identifiers 0x102 and 0x200, full red, 100
// percent brightness and auto mode off. The APB port is always ready.
`default_nettype none

module can_commanded_led_color_controller #(
  parameter int LED_COUNT = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Frame input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // frame_id, action, red_in, green_in, blue_in, level_in
  // LED word output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // led_index, grb_word
  output logic             m_tlast
);

  logic [10:0]    color_frame_id;
  logic [10:0]    mode_frame_id;
  logic           push;
  logic           push_ready;
  cled_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop;
  cled_pkg::cmd_t pop_cmd;
  logic [5:0]     led_index;
  logic [23:0]    grb_word;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_frame_id <= cled_pkg::COLOR_ID_RESET;
      mode_frame_id  <= cled_pkg::MODE_ID_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        cled_pkg::REG_COLOR_ID: color_frame_id <= pwdata[10:0];
        cled_pkg::REG_MODE_ID:  mode_frame_id  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cled_pkg::REG_COLOR_ID: prdata = {21'd0, color_frame_id};
      cled_pkg::REG_MODE_ID:  prdata = {21'd0, mode_frame_id};
      default:                prdata = '0;
    endcase
  end

  cled_front u_front (
    .clk            (clk),
    .rst            (rst),
    .color_frame_id (color_frame_id),
    .mode_frame_id  (mode_frame_id),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .frame_id       (s_tdata[10:0]),
    .action         (s_tdata[18:11]),
    .red_in         (s_tdata[26:19]),
    .green_in       (s_tdata[34:27]),
    .blue_in        (s_tdata[42:35]),
    .level_in       (s_tdata[50:43]),
    .push           (push),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  cled_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  cled_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_idx   (led_index),
    .out_word  (grb_word),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, grb_word, led_index};

endmodule

`default_nettype wire

@@ sim/cled_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the LED controller,
// predicts the LED words of every refresh and compares them as they leave.
module cled_checker #(
  parameter int LED_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  output int          failures,
  output int          backlog
);

  typedef struct packed {
    logic [5:0]  led;
    logic [23:0] grb;
    logic        last;
  } led_word_t;

  // Shadow of the registers and of the display state.
  logic [10:0] color_id;
  logic [10:0] mode_id;
  logic [7:0]  keep_red;
  logic [7:0]  keep_green;
  logic [7:0]  keep_blue;
  logic [6:0]  level_pct;
  logic        auto_on;
  logic [23:0] display;

  led_word_t words_due[$];
  led_word_t want;
  logic [31:0] reg_now;

  initial begin
    failures = 0;
    backlog  = 0;
  end

  // One color component dimmed to a percentage, rounded down.
  function automatic logic [7:0] dimmed(input logic [7:0] c, input logic [6:0] pct);
    int unsigned prod;
    prod = int'(c) * int'(pct);
    return 8'(prod / 100);
  endfunction

  function automatic logic [23:0] grb_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [6:0] pct);
    return {dimmed(g, pct), dimmed(r, pct), dimmed(b, pct)};
  endfunction

  // A refresh sends the displayed color once per LED of the chain.
  task automatic queue_refresh();
    led_word_t w;
    for (int i = 0; i < LED_COUNT; i++) begin
      w.led  = 6'(i);
      w.grb  = display;
      w.last = (i == LED_COUNT - 1);
      words_due.push_back(w);
    end
  endtask

  // Applies one accepted frame to the shadow state.
  task automatic take_frame(input logic [55:0] d);
    logic [10:0] id;
    logic [7:0]  act;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  lvl;
    logic [6:0]  pct;
    id  = d[10:0];
    act = d[18:11];
    r   = d[26:19];
    g   = d[34:27];
    b   = d[42:35];
    lvl = d[50:43];
    if (id == color_id) begin
      case (act)
        cled_pkg::ACT_OFF: begin
          display = '0;
        end
        cled_pkg::ACT_ON: begin
          display = grb_of(keep_red, keep_green, keep_blue,
                           auto_on ? cled_pkg::FULL_PCT : level_pct);
        end
        cled_pkg::ACT_BRIGHT: begin
          pct = (lvl > {1'b0, cled_pkg::FULL_PCT}) ? cled_pkg::FULL_PCT : lvl[6:0];
          level_pct = pct;
          display = grb_of(keep_red, keep_green, keep_blue, pct);
        end
        cled_pkg::ACT_COLOR: begin
          // In auto mode the color is shown at full level and not kept.
          if (auto_on) begin
            display = grb_of(r, g, b, cled_pkg::FULL_PCT);
          end else begin
            keep_red   = r;
            keep_green = g;
            keep_blue  = b;
            display = grb_of(r, g, b, level_pct);
          end
        end
        default: begin
        end
      endcase
      auto_on = 1'b0;
      queue_refresh();
    end else if (id == mode_id) begin
      if (act == cled_pkg::ACT_ON) begin
        auto_on = 1'b1;
      end else if (act == cled_pkg::ACT_OFF) begin
        display = '0;
        auto_on = 1'b0;
        queue_refresh();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      color_id   = cled_pkg::COLOR_ID_RESET;
      mode_id    = cled_pkg::MODE_ID_RESET;
      keep_red   = cled_pkg::STORED_RED_RESET;
      keep_green = cled_pkg::STORED_GREEN_RESET;
      keep_blue  = cled_pkg::STORED_BLUE_RESET;
      level_pct  = cled_pkg::FULL_PCT;
      auto_on    = 1'b0;
      display    = cled_pkg::SHOWN_RESET;
      words_due.delete();
    end else begin
      // Register writes update the shadow; reads are compared against it.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == cled_pkg::REG_COLOR_ID) color_id = pwdata[10:0];
          else mode_id = pwdata[10:0];
        end else begin
          reg_now = {21'b0, (paddr[2] == cled_pkg::REG_COLOR_ID) ? color_id : mode_id};
          if (prdata !== reg_now) begin
            $error("prdata: expected %0h, got %0h", reg_now, prdata);
            failures++;
          end
        end
      end

      // Each LED word transfer is matched against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          $error("LED word with nothing pending: led_index %0d, grb_word %06h",
                 m_tdata[5:0], m_tdata[29:6]);
          failures++;
        end else begin
          want = words_due.pop_front();
          if (m_tdata[5:0] !== want.led) begin
            $error("led_index: expected %0d, got %0d", want.led, m_tdata[5:0]);
            failures++;
          end
          if (m_tdata[29:6] !== want.grb) begin
            $error("grb_word: expected %06h, got %06h", want.grb, m_tdata[29:6]);
            failures++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            failures++;
          end
        end
      end

      if (s_tvalid && s_tready) take_frame(s_tdata);
    end
    backlog = words_due.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int LED_COUNT    = 5;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int SETTLE_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // frame_id, action, red_in, green_in, blue_in, level_in
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // led_index, grb_word
  logic        m_tlast;

  int failures;
  int backlog;

  // Stimulus controls; steady, hold_req and hold_done are shared with the receiver process.
  logic        steady;
  logic        hold_req;
  logic        hold_done;
  logic [10:0] color_id_now;
  logic [10:0] mode_id_now;

  can_commanded_led_color_controller #(.LED_COUNT(LED_COUNT)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  cled_checker #(.LED_COUNT(LED_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .failures(failures), .backlog(backlog)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2_400_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Offers one frame and returns after its transfer, at a falling edge.
  task automatic send_frame(input logic [10:0] id, input logic [7:0] act,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] lvl);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, lvl, b, g, r, act, id};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Setup and access cycle on the configuration port.
  task automatic apb_access(input logic write, input logic reg_sel, input logic [10:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {21'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ids(input logic [10:0] color_id, input logic [10:0] mode_id);
    apb_access(1'b1, cled_pkg::REG_COLOR_ID, color_id);
    apb_access(1'b1, cled_pkg::REG_MODE_ID, mode_id);
    apb_access(1'b0, cled_pkg::REG_COLOR_ID, '0);
    apb_access(1'b0, cled_pkg::REG_MODE_ID, '0);
    color_id_now = color_id;
    mode_id_now  = mode_id;
  endtask

  // Stops offering frames and lets every pending refresh drain.
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (backlog != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly color and mode frames with random content, some stray frames.
  task automatic random_frames(input int n);
    int          pick;
    logic [10:0] id;
    logic [7:0]  act;
    logic [7:0]  lvl;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        id  = color_id_now;
        act = ($urandom_range(0, 9) == 0)
              ? 8'($urandom)
              : 8'($urandom_range(cled_pkg::ACT_COLOR, cled_pkg::ACT_OFF));
      end else if (pick < 75) begin
        id  = mode_id_now;
        act = ($urandom_range(0, 6) == 0)
              ? 8'($urandom)
              : 8'($urandom_range(cled_pkg::ACT_ON, cled_pkg::ACT_OFF));
      end else begin
        id  = 11'($urandom);
        act = 8'($urandom);
      end
      lvl = $urandom_range(0, 1) ? 8'($urandom_range(0, 100)) : 8'($urandom);
      send_frame(id, act, 8'($urandom), 8'($urandom), 8'($urandom), lvl);
    end
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    color_id_now = cled_pkg::COLOR_ID_RESET;
    mode_id_now  = cled_pkg::MODE_ID_RESET;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames under the reset identifiers.
    send_frame(color_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd50);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd255);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd101);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd0);
    send_frame(color_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd100);
    send_frame(color_id_now, cled_pkg::ACT_COLOR, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd37);
    send_frame(color_id_now, cled_pkg::ACT_COLOR, 8'h12, 8'hAB, 8'hFE, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(color_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    // Unknown actions repeat the current color.
    send_frame(color_id_now, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Auto mode: on shows unscaled, color is shown but not kept.
    send_frame(mode_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(mode_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_COLOR, 8'h80, 8'h40, 8'hC0, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(mode_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(color_id_now, cled_pkg::ACT_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd1);
    // Auto off from the mode frame blanks the chain; other mode actions do nothing.
    send_frame(mode_id_now, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(mode_id_now, cled_pkg::ACT_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(mode_id_now, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(11'h000, cled_pkg::ACT_ON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(11'h7FF, cled_pkg::ACT_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // Extreme identifiers, with a long receiver hold-off to fill the block.
    set_ids(11'h000, 11'h7FF);
    hold_req = 1'b1;
    random_frames(55);
    settle();

    // Equal identifiers make every such frame a color frame; no idling here.
    set_ids(11'h2AA, 11'h2AA);
    steady = 1'b1;
    random_frames(50);
    settle();
    steady = 1'b0;

    set_ids(11'h7FF, 11'h000);
    random_frames(50);
    settle();

    set_ids(11'($urandom), 11'($urandom));
    random_frames(50);
    settle();

    if (failures == 0 && backlog == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cled_pkg.sv
src/cled_front.sv
src/cled_fifo.sv
src/cled_back.sv
src/can_commanded_led_color_controller.sv
sim/cled_checker.sv
sim/tb_top.sv
